// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Every check is clocked on clk_i and
// disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define HCB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check that cause at one edge is followed by effect at the next edge.
`define HCB_ASSERT_NEXT(lbl, cause, effect) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cause) |=> (effect)) \
    else $error("assertion failed");

`endif

// ===== rtl/hcb_pkg.sv =====
package hcb_pkg;

  // Sizes of the code builder
  localparam int SYMBOLS    = 256;
  localparam int COUNT_BITS = 20;
  localparam int CODE_W     = 32;
  localparam int SYM_W      = 8;
  localparam int NODE_AW    = 9;
  localparam int DEPTH_W    = 8;
  localparam int LEN_W      = 6;
  localparam int TOT_W      = 26;
  localparam int PROD_W     = COUNT_BITS + DEPTH_W;

  // Input commands
  localparam logic [2:0] CMD_COUNT  = 3'd0;
  localparam logic [2:0] CMD_BUILD  = 3'd1;
  localparam logic [2:0] CMD_ENCODE = 3'd2;
  localparam logic [2:0] CMD_FLUSH  = 3'd3;
  localparam logic [2:0] CMD_QUERY  = 3'd4;
  localparam logic [2:0] CMD_CLEAR  = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_REPORT = 2'd0;
  localparam logic [1:0] KIND_BYTE   = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  // Datapath operations issued by the controller, one per cycle
  typedef enum logic [4:0] {
    OP_IDLE, OP_ACCEPT, OP_COUNT, OP_CLEAR, OP_QUERY, OP_FLUSH, OP_ENC_LOAD,
    OP_ENC_BIT, OP_B_INIT, OP_S_READ, OP_S_SKIP, OP_S_LEAF, OP_INS_READ,
    OP_INS_ADV, OP_INS_OPEN, OP_SH_READ, OP_SH_WRITE, OP_INS_PUT, OP_M_READA,
    OP_M_READB, OP_M_MERGE, OP_Q_EMPTY, OP_W_READ, OP_W_ROOT, OP_W_POP,
    OP_W_NODE, OP_W_LEAF, OP_W_PUSHHI, OP_W_PUSHLO, OP_W_ACC, OP_REPORT
  } op_e;

  // Queue entry: node id, count, leaf flag
  typedef struct packed {
    logic [NODE_AW-1:0]    id;
    logic [COUNT_BITS-1:0] cnt;
    logic                  leaf;
  } qent_t;

  // Tree node
  typedef struct packed {
    logic [COUNT_BITS-1:0] cnt;
    logic [NODE_AW-1:0]    lo;
    logic [NODE_AW-1:0]    hi;
    logic                  leaf;
    logic [SYM_W-1:0]      sym;
  } node_t;

  // Walk stack entry
  typedef struct packed {
    logic [NODE_AW-1:0] node;
    logic [DEPTH_W-1:0] depth;
    logic [CODE_W-1:0]  code;
  } stk_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       out_free;
    logic       pend_zero;
    logic       pc7;
    logic       enc_done;
    logic       hist_nz;
    logic       sym_last;
    logic       p_lt_tail;
    logic       ins_adv;
    logic       idx_gt_p;
    logic       q_empty;
    logic       q_multi;
    logic       sp_zero;
    logic       node_leaf;
  } stat_t;

endpackage

// ===== rtl/huffman_code_builder_encoder.sv =====
// Each item is accepted and then dispatched on its command. A query, or a flush with
// pending bits, waits while the output register is held. Encode loads the code and shifts out one code bit at a time,
// and a bit that completes a byte waits for a free output register.
// Build sweeps the 256 symbols, scans or shifts queue slots on each of up
// to 511 sorted inserts, merges the two smallest entries, walks the tree nodes, then reports.
// Reset clears histogram, code lengths, totals and pending bits at once.
module huffman_code_builder_encoder import hcb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        cmd_i,
  input  logic [SYM_W-1:0]  data_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        kind_o,
  output logic [7:0]        packed_byte_o,
  output logic [LEN_W-1:0]  code_len_o,
  output logic [CODE_W-1:0] code_value_o,
  output logic              symbol_present_o,
  output logic [24:0]       total_bits_o,
  output logic              overflow_o,
  output logic              last_o
);

  stat_t stat;
  op_e   op;

  // Sequencer
  hcb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .op_o       (op)
  );

  // Tables, queue, tree walk and output register
  hcb_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (op),
    .cmd_i            (cmd_i),
    .data_byte_i      (data_byte_i),
    .stat_o           (stat),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .packed_byte_o    (packed_byte_o),
    .code_len_o       (code_len_o),
    .code_value_o     (code_value_o),
    .symbol_present_o (symbol_present_o),
    .total_bits_o     (total_bits_o),
    .overflow_o       (overflow_o),
    .last_o           (last_o)
  );

endmodule

// ===== rtl/hcb_ctrl.sv =====
module hcb_ctrl import hcb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output op_e   op_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_ENC    = 5'd2;
  localparam logic [4:0] S_SRD    = 5'd3;
  localparam logic [4:0] S_SCHK   = 5'd4;
  localparam logic [4:0] S_INSRD  = 5'd5;
  localparam logic [4:0] S_INSCMP = 5'd6;
  localparam logic [4:0] S_SHRD   = 5'd7;
  localparam logic [4:0] S_SHWR   = 5'd8;
  localparam logic [4:0] S_MCHK   = 5'd9;
  localparam logic [4:0] S_MA     = 5'd10;
  localparam logic [4:0] S_MB     = 5'd11;
  localparam logic [4:0] S_WROOT  = 5'd12;
  localparam logic [4:0] S_WPOP   = 5'd13;
  localparam logic [4:0] S_WNODE  = 5'd14;
  localparam logic [4:0] S_WEVAL  = 5'd15;
  localparam logic [4:0] S_WPUSH  = 5'd16;
  localparam logic [4:0] S_WACC   = 5'd17;
  localparam logic [4:0] S_RPT    = 5'd18;

  logic [4:0] state_q, state_d;
  logic       leaf_ph_q, leaf_ph_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Pick the next state and the datapath operation
  always_comb begin
    state_d   = state_q;
    leaf_ph_d = leaf_ph_q;
    op_o      = OP_IDLE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = OP_ACCEPT;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.cmd)
          CMD_COUNT: begin
            op_o    = OP_COUNT;
            state_d = S_IDLE;
          end
          CMD_CLEAR: begin
            op_o    = OP_CLEAR;
            state_d = S_IDLE;
          end
          CMD_QUERY: begin
            if (stat_i.out_free) begin
              op_o    = OP_QUERY;
              state_d = S_IDLE;
            end
          end
          CMD_FLUSH: begin
            if (stat_i.pend_zero) begin
              state_d = S_IDLE;
            end else if (stat_i.out_free) begin
              op_o    = OP_FLUSH;
              state_d = S_IDLE;
            end
          end
          CMD_ENCODE: begin
            op_o    = OP_ENC_LOAD;
            state_d = S_ENC;
          end
          CMD_BUILD: begin
            op_o      = OP_B_INIT;
            leaf_ph_d = 1'b1;
            state_d   = S_SRD;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_ENC: begin
        if (stat_i.enc_done) begin
          state_d = S_IDLE;
        end else if (!stat_i.pc7 || stat_i.out_free) begin
          op_o = OP_ENC_BIT;
        end
      end
      S_SRD: begin
        op_o    = OP_S_READ;
        state_d = S_SCHK;
      end
      S_SCHK: begin
        if (stat_i.hist_nz) begin
          op_o    = OP_S_LEAF;
          state_d = S_INSRD;
        end else begin
          op_o    = OP_S_SKIP;
          state_d = stat_i.sym_last ? S_MCHK : S_SRD;
        end
      end
      S_INSRD: begin
        if (stat_i.p_lt_tail) begin
          op_o    = OP_INS_READ;
          state_d = S_INSCMP;
        end else begin
          op_o    = OP_INS_OPEN;
          state_d = S_SHRD;
        end
      end
      S_INSCMP: begin
        if (stat_i.ins_adv) begin
          op_o    = OP_INS_ADV;
          state_d = S_INSRD;
        end else begin
          op_o    = OP_INS_OPEN;
          state_d = S_SHRD;
        end
      end
      S_SHRD: begin
        if (stat_i.idx_gt_p) begin
          op_o    = OP_SH_READ;
          state_d = S_SHWR;
        end else begin
          op_o = OP_INS_PUT;
          if (leaf_ph_q && !stat_i.sym_last) begin
            state_d = S_SRD;
          end else begin
            state_d = S_MCHK;
          end
        end
      end
      S_SHWR: begin
        op_o    = OP_SH_WRITE;
        state_d = S_SHRD;
      end
      S_MCHK: begin
        leaf_ph_d = 1'b0;
        if (stat_i.q_empty) begin
          op_o    = OP_Q_EMPTY;
          state_d = S_RPT;
        end else if (stat_i.q_multi) begin
          op_o    = OP_M_READA;
          state_d = S_MA;
        end else begin
          op_o    = OP_W_READ;
          state_d = S_WROOT;
        end
      end
      S_MA: begin
        op_o    = OP_M_READB;
        state_d = S_MB;
      end
      S_MB: begin
        op_o    = OP_M_MERGE;
        state_d = S_INSRD;
      end
      S_WROOT: begin
        op_o    = OP_W_ROOT;
        state_d = S_WPOP;
      end
      S_WPOP: begin
        if (stat_i.sp_zero) begin
          state_d = S_RPT;
        end else begin
          op_o    = OP_W_POP;
          state_d = S_WNODE;
        end
      end
      S_WNODE: begin
        op_o    = OP_W_NODE;
        state_d = S_WEVAL;
      end
      S_WEVAL: begin
        if (stat_i.node_leaf) begin
          op_o    = OP_W_LEAF;
          state_d = S_WACC;
        end else begin
          op_o    = OP_W_PUSHHI;
          state_d = S_WPUSH;
        end
      end
      S_WPUSH: begin
        op_o    = OP_W_PUSHLO;
        state_d = S_WPOP;
      end
      S_WACC: begin
        op_o    = OP_W_ACC;
        state_d = S_WPOP;
      end
      S_RPT: begin
        if (stat_i.out_free) begin
          op_o    = OP_REPORT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      leaf_ph_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      leaf_ph_q <= leaf_ph_d;
    end
  end

endmodule

// ===== rtl/hcb_dp.sv =====
`include "assert_macros.svh"

module hcb_dp import hcb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  op_e              op_i,
  input  logic [2:0]       cmd_i,
  input  logic [SYM_W-1:0] data_byte_i,
  output stat_t            stat_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       packed_byte_o,
  output logic [LEN_W-1:0] code_len_o,
  output logic [CODE_W-1:0] code_value_o,
  output logic             symbol_present_o,
  output logic [24:0]      total_bits_o,
  output logic             overflow_o,
  output logic             last_o
);

  // Memories
  logic [COUNT_BITS-1:0] hist_mem [SYMBOLS];
  logic [LEN_W-1:0]      len_mem  [SYMBOLS];
  logic [CODE_W-1:0]     bits_mem [SYMBOLS];
  qent_t                 q_mem    [2**NODE_AW];
  node_t                 node_mem [2**NODE_AW];
  stk_t                  stk_mem  [2**NODE_AW];

  logic [SYMBOLS-1:0]    hist_vld_q, len_vld_q;
  logic [COUNT_BITS-1:0] hist_rd_q;
  logic                  hist_vrd_q;
  logic [LEN_W-1:0]      len_rd_q;
  logic                  len_vrd_q;
  logic [CODE_W-1:0]     bits_rd_q;
  qent_t                 q_rd_q;
  node_t                 node_rd_q;
  stk_t                  stk_rd_q;

  // Control and work registers
  logic [2:0]            cmd_q;
  logic [SYM_W-1:0]      byte_q;
  logic [COUNT_BITS-1:0] bt_q;
  logic                  ovf_q;
  logic [SYM_W-1:0]      sym_q;
  logic [NODE_AW-1:0]    head_q, tail_q, used_q, p_q, idx_q, sp_q;
  qent_t                 ent_q, a_q;
  logic [DEPTH_W-1:0]    wd_q;
  logic [CODE_W-1:0]     wc_q;
  logic [PROD_W-1:0]     prod_q;
  logic [TOT_W-1:0]      total_q;
  logic [6:0]            pend_q;
  logic [2:0]            pc_q;
  logic [LEN_W-1:0]      enc_len_q;
  logic [CODE_W-1:0]     sh_q;
  logic [2:0]            rem_q;

  // Combinational helpers
  logic [COUNT_BITS-1:0] hist_g;
  logic [LEN_W-1:0]      len_g, len_c;
  logic [LEN_W-1:0]      sum_bits;
  logic [DEPTH_W-1:0]    nd;
  logic [LEN_W-1:0]      len_sat;
  logic [7:0]            flush_byte;
  logic [3:0]            flush_sh;
  logic                  out_free, load;

  logic                  hist_we, hist_re, len_we, bits_we, q_we, q_re;
  logic                  node_we, node_re, stk_we, stk_re;
  logic [SYM_W-1:0]      hist_ra, len_wa;
  logic [LEN_W-1:0]      len_wd;
  logic [NODE_AW-1:0]    q_ra, q_wa, node_wa, stk_ra, stk_wa;
  qent_t                 q_wd;
  node_t                 node_wd;
  stk_t                  stk_wd;

  assign hist_g   = hist_vrd_q ? hist_rd_q : '0;
  assign len_g    = len_vrd_q ? len_rd_q : '0;
  assign len_c    = (len_g > LEN_W'(CODE_W)) ? LEN_W'(CODE_W) : len_g;
  assign sum_bits = LEN_W'(pc_q) + len_c;
  assign nd       = (wd_q == '1) ? wd_q : wd_q + DEPTH_W'(1);
  assign len_sat  = (wd_q > DEPTH_W'(63)) ? LEN_W'(63) : wd_q[LEN_W-1:0];
  assign flush_sh = 4'd8 - {1'b0, pc_q};
  assign flush_byte = 8'({1'b0, pend_q} << flush_sh);
  assign out_free = !out_valid_o || out_ready_i;
  assign load     = (op_i == OP_QUERY) || (op_i == OP_FLUSH) || (op_i == OP_REPORT) ||
                    ((op_i == OP_ENC_BIT) && (pc_q == 3'd7));

  // Status to the controller
  always_comb begin
    stat_o.cmd       = cmd_q;
    stat_o.out_free  = out_free;
    stat_o.pend_zero = (pc_q == 3'd0);
    stat_o.pc7       = (pc_q == 3'd7);
    stat_o.enc_done  = (enc_len_q == '0);
    stat_o.hist_nz   = (hist_g != '0);
    stat_o.sym_last  = (sym_q == SYM_W'(SYMBOLS - 1));
    stat_o.p_lt_tail = (p_q < tail_q);
    stat_o.ins_adv   = (ent_q.cnt > q_rd_q.cnt) ||
                       (!ent_q.leaf && (ent_q.cnt == q_rd_q.cnt) && q_rd_q.leaf);
    stat_o.idx_gt_p  = (idx_q > p_q);
    stat_o.q_empty   = (tail_q == head_q);
    stat_o.q_multi   = ((tail_q - head_q) > NODE_AW'(1));
    stat_o.sp_zero   = (sp_q == '0);
    stat_o.node_leaf = node_rd_q.leaf;
  end

  // Memory port selection
  always_comb begin
    hist_re = (op_i == OP_ACCEPT) || (op_i == OP_S_READ);
    hist_ra = (op_i == OP_ACCEPT) ? data_byte_i : sym_q;
    hist_we = (op_i == OP_COUNT) && (bt_q != '1);
    len_we  = (op_i == OP_S_READ) || (op_i == OP_W_LEAF);
    len_wa  = (op_i == OP_S_READ) ? sym_q : node_rd_q.sym;
    len_wd  = (op_i == OP_S_READ) ? '0 : len_sat;
    bits_we = (op_i == OP_W_LEAF);
    q_re    = (op_i == OP_INS_READ) || (op_i == OP_SH_READ) || (op_i == OP_M_READA) ||
              (op_i == OP_M_READB) || (op_i == OP_W_READ);
    case (op_i)
      OP_INS_READ: q_ra = p_q;
      OP_SH_READ:  q_ra = idx_q - NODE_AW'(1);
      OP_M_READB:  q_ra = head_q + NODE_AW'(1);
      default:     q_ra = head_q;
    endcase
    q_we = (op_i == OP_SH_WRITE) || (op_i == OP_INS_PUT);
    q_wa = (op_i == OP_SH_WRITE) ? idx_q : p_q;
    q_wd = (op_i == OP_SH_WRITE) ? q_rd_q : ent_q;
    node_we = (op_i == OP_S_LEAF) || (op_i == OP_M_MERGE);
    node_wa = used_q;
    if (op_i == OP_S_LEAF) begin
      node_wd = '{cnt: hist_g, lo: '0, hi: '0, leaf: 1'b1, sym: sym_q};
    end else begin
      node_wd = '{cnt: a_q.cnt + q_rd_q.cnt, lo: a_q.id, hi: q_rd_q.id, leaf: 1'b0,
                  sym: '0};
    end
    node_re = (op_i == OP_W_NODE);
    stk_re  = (op_i == OP_W_POP);
    stk_ra  = sp_q - NODE_AW'(1);
    stk_we  = (op_i == OP_W_ROOT) || (op_i == OP_W_PUSHHI) || (op_i == OP_W_PUSHLO);
    stk_wa  = (op_i == OP_W_ROOT) ? '0 : sp_q;
    case (op_i)
      OP_W_ROOT:   stk_wd = '{node: q_rd_q.id, depth: '0, code: '0};
      OP_W_PUSHHI: stk_wd = '{node: node_rd_q.hi, depth: nd, code: {wc_q[CODE_W-2:0], 1'b1}};
      default:     stk_wd = '{node: node_rd_q.lo, depth: nd, code: {wc_q[CODE_W-2:0], 1'b0}};
    endcase
  end

  // Memory arrays with registered reads
  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[byte_q] <= hist_g + COUNT_BITS'(1);
    if (hist_re) hist_rd_q <= hist_mem[hist_ra];
    if (len_we) len_mem[len_wa] <= len_wd;
    if (bits_we) bits_mem[node_rd_q.sym] <= wc_q;
    if (op_i == OP_ACCEPT) begin
      len_rd_q  <= len_mem[data_byte_i];
      bits_rd_q <= bits_mem[data_byte_i];
    end
    if (q_we) q_mem[q_wa] <= q_wd;
    if (q_re) q_rd_q <= q_mem[q_ra];
    if (node_we) node_mem[node_wa] <= node_wd;
    if (node_re) node_rd_q <= node_mem[stk_rd_q.node];
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_re) stk_rd_q <= stk_mem[stk_ra];
  end

  // Valid bits of the tables that reset clears
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      len_vld_q  <= '0;
      hist_vrd_q <= 1'b0;
      len_vrd_q  <= 1'b0;
    end else begin
      if (op_i == OP_CLEAR) hist_vld_q <= '0;
      else if (hist_we) hist_vld_q[byte_q] <= 1'b1;
      if (len_we) len_vld_q[len_wa] <= 1'b1;
      if (hist_re) hist_vrd_q <= hist_vld_q[hist_ra];
      if (op_i == OP_ACCEPT) len_vrd_q <= len_vld_q[data_byte_i];
    end
  end

  // Payload work registers
  always_ff @(posedge clk_i) begin
    if (op_i == OP_ACCEPT) byte_q <= data_byte_i;
    if (op_i == OP_S_LEAF) ent_q <= '{id: used_q, cnt: hist_g, leaf: 1'b1};
    if (op_i == OP_M_MERGE) ent_q <= '{id: used_q, cnt: a_q.cnt + q_rd_q.cnt, leaf: 1'b0};
    if (op_i == OP_M_READB) a_q <= q_rd_q;
    if (op_i == OP_W_NODE) begin
      wd_q <= stk_rd_q.depth;
      wc_q <= stk_rd_q.code;
    end
    if (op_i == OP_W_LEAF) prod_q <= node_rd_q.cnt * wd_q;
    if (op_i == OP_ENC_LOAD) sh_q <= bits_rd_q << (LEN_W'(CODE_W) - len_c);
    else if (op_i == OP_ENC_BIT) sh_q <= {sh_q[CODE_W-2:0], 1'b0};
  end

  // Control registers of the passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q     <= CMD_COUNT;
      bt_q      <= '0;
      ovf_q     <= 1'b0;
      sym_q     <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      used_q    <= '0;
      p_q       <= '0;
      idx_q     <= '0;
      sp_q      <= '0;
      total_q   <= '0;
      pend_q    <= '0;
      pc_q      <= '0;
      enc_len_q <= '0;
      rem_q     <= '0;
    end else begin
      case (op_i)
        OP_ACCEPT: cmd_q <= cmd_i;
        OP_COUNT: begin
          if (bt_q != '1) bt_q <= bt_q + COUNT_BITS'(1);
          else ovf_q <= 1'b1;
        end
        OP_CLEAR: begin
          bt_q  <= '0;
          ovf_q <= 1'b0;
        end
        OP_FLUSH: begin
          pend_q <= '0;
          pc_q   <= '0;
        end
        OP_ENC_LOAD: begin
          enc_len_q <= len_c;
          rem_q     <= sum_bits[5:3];
        end
        OP_ENC_BIT: begin
          enc_len_q <= enc_len_q - LEN_W'(1);
          if (pc_q == 3'd7) begin
            pend_q <= '0;
            pc_q   <= '0;
            rem_q  <= rem_q - 3'd1;
          end else begin
            pend_q <= {pend_q[5:0], sh_q[CODE_W-1]};
            pc_q   <= pc_q + 3'd1;
          end
        end
        OP_B_INIT: begin
          sym_q  <= '0;
          head_q <= '0;
          tail_q <= '0;
          used_q <= '0;
        end
        OP_S_SKIP: sym_q <= sym_q + SYM_W'(1);
        OP_S_LEAF: begin
          used_q <= used_q + NODE_AW'(1);
          p_q    <= head_q;
        end
        OP_INS_ADV:  p_q <= p_q + NODE_AW'(1);
        OP_INS_OPEN: idx_q <= tail_q;
        OP_SH_WRITE: idx_q <= idx_q - NODE_AW'(1);
        OP_INS_PUT: begin
          tail_q <= tail_q + NODE_AW'(1);
          sym_q  <= sym_q + SYM_W'(1);
        end
        OP_M_MERGE: begin
          used_q <= used_q + NODE_AW'(1);
          head_q <= head_q + NODE_AW'(2);
          p_q    <= head_q + NODE_AW'(2);
        end
        OP_Q_EMPTY: total_q <= '0;
        OP_W_ROOT: begin
          sp_q    <= NODE_AW'(1);
          total_q <= '0;
        end
        OP_W_POP:    sp_q <= sp_q - NODE_AW'(1);
        OP_W_PUSHHI: sp_q <= sp_q + NODE_AW'(1);
        OP_W_PUSHLO: sp_q <= sp_q + NODE_AW'(1);
        OP_W_ACC:    total_q <= total_q + prod_q[TOT_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_o           <= KIND_BYTE;
      packed_byte_o    <= '0;
      code_len_o       <= '0;
      code_value_o     <= '0;
      symbol_present_o <= 1'b0;
      total_bits_o     <= '0;
      overflow_o       <= 1'b0;
      last_o           <= 1'b1;
      case (op_i)
        OP_QUERY: begin
          kind_o           <= KIND_QUERY;
          code_len_o       <= len_g;
          code_value_o     <= (len_g != '0) ? bits_rd_q : '0;
          symbol_present_o <= (hist_g != '0);
        end
        OP_FLUSH: packed_byte_o <= flush_byte;
        OP_REPORT: begin
          kind_o       <= KIND_REPORT;
          total_bits_o <= total_q[24:0];
          overflow_o   <= ovf_q;
        end
        default: begin
          packed_byte_o <= {pend_q, sh_q[CODE_W-1]};
          last_o        <= (rem_q == 3'd1);
        end
      endcase
    end
  end

  `HCB_ASSERT(a_load_free, load |-> (!out_valid_o || out_ready_i))
  `HCB_ASSERT(a_enc_rem, ((op_i == OP_ENC_BIT) && (pc_q == 3'd7)) |-> (rem_q != 3'd0))
  `HCB_ASSERT_NEXT(a_enc_emit, ((op_i == OP_ENC_BIT) && (pc_q == 3'd7)), out_valid_o)
  `HCB_ASSERT(a_queue_order, tail_q >= head_q)

endmodule
